FILE: hdl/qxm_pkg.sv
// Shared types, constants and helper functions for the quad X motor mixer.
// No dependencies; every other file in the block refers to this package.

package qxm_pkg;

   localparam int STAGE_TIME_MS_DEF = 300;
   localparam int PWM_FULL_DEF      = 1000;

   localparam int TICK_W     = 8;
   localparam int CMD_W      = 16;
   localparam int PWM_W      = 10;
   localparam int IDLE_W     = 8;
   localparam int IDLE_PWM_W = 9;
   localparam int SUM_W      = CMD_W + 2;
   localparam int MOTORS     = 4;

   localparam logic [IDLE_W-1:0] IDLE_LIMIT = IDLE_W'(30);

   typedef logic [PWM_W-1:0]      pwm_type;
   typedef logic [IDLE_PWM_W-1:0] idle_pwm_type;
   typedef logic signed [CMD_W-1:0] cmd_type;

   // Per-tick status from the spin-up sequencer to the output mux.
   typedef struct packed {
      logic              mixing;
      logic [MOTORS-1:0] motor_on;
   } spin_status_type;

   // Idle PWM is ten times the setting, with the setting clamped to its limit.
   function automatic idle_pwm_type idle_pwm(input logic [IDLE_W-1:0] setting);
      logic [IDLE_W-1:0] clamped;
      clamped = (setting > IDLE_LIMIT) ? IDLE_LIMIT : setting;
      return (IDLE_PWM_W'(clamped) << 3) + (IDLE_PWM_W'(clamped) << 1);
   endfunction

endpackage

FILE: hdl/qxm_channels.sv
// Valid/ready channel interfaces for the tick requests and the motor responses.
// Depends on qxm_pkg for field widths.

interface qxm_req_if;
   logic                            valid;
   logic                            ready;
   logic [qxm_pkg::TICK_W-1:0]      tick_ms;
   logic                            armed;
   logic signed [qxm_pkg::CMD_W-1:0] throttle;
   logic signed [qxm_pkg::CMD_W-1:0] yaw_cmd;
   logic signed [qxm_pkg::CMD_W-1:0] roll_cmd;
   logic signed [qxm_pkg::CMD_W-1:0] pitch_cmd;

   modport source (output valid, tick_ms, armed, throttle, yaw_cmd, roll_cmd, pitch_cmd,
                   input ready);
   modport sink (input valid, tick_ms, armed, throttle, yaw_cmd, roll_cmd, pitch_cmd,
                 output ready);
endinterface

interface qxm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [qxm_pkg::PWM_W-1:0] motor_front_right;
   logic [qxm_pkg::PWM_W-1:0] motor_front_left;
   logic [qxm_pkg::PWM_W-1:0] motor_rear_left;
   logic [qxm_pkg::PWM_W-1:0] motor_rear_right;
   logic                      spinup_done;

   modport source (output valid, motor_front_right, motor_front_left, motor_rear_left,
                   motor_rear_right, spinup_done, input ready);
   modport sink (input valid, motor_front_right, motor_front_left, motor_rear_left,
                 motor_rear_right, spinup_done, output ready);
endinterface

FILE: hdl/qxm_spinup.sv
// Spin-up sequencer: holds the spin-up counter and completion flag and
// decides per tick which motors idle or whether the mixer drives them. Uses qxm_pkg.

module qxm_spinup #(
   parameter int STAGE_TIME_MS = qxm_pkg::STAGE_TIME_MS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          armed,
   input  logic [qxm_pkg::TICK_W-1:0]    tick_ms,
   output qxm_pkg::spin_status_type      status
);

   // Counter plus tick never exceeds four stages plus one maximal tick minus one.
   localparam int CNT_W = $clog2(4 * STAGE_TIME_MS + 255);
   localparam logic [CNT_W-1:0] SPIN_END = CNT_W'(4 * STAGE_TIME_MS);

   logic [CNT_W-1:0] spinup_ms_ff, spinup_ms_in;
   logic             complete_ff, complete_in;
   logic [CNT_W-1:0] count_sum;

   assign count_sum = spinup_ms_ff + CNT_W'(tick_ms);

   always_comb begin
      spinup_ms_in    = spinup_ms_ff;
      complete_in     = complete_ff;
      status.mixing   = 1'b0;
      status.motor_on = '0;
      if (!armed) begin
         complete_in = 1'b0;
      end else if (complete_ff) begin
         status.mixing = 1'b1;
      end else if (count_sum < SPIN_END) begin
         spinup_ms_in = count_sum;
         for (int k = 0; k < qxm_pkg::MOTORS; k++) begin
            status.motor_on[k] = (count_sum >= CNT_W'(STAGE_TIME_MS * k));
         end
      end else begin
         // The last stage has run out; mixing starts on this same tick.
         spinup_ms_in  = '0;
         complete_in   = 1'b1;
         status.mixing = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spinup_ms_ff <= '0;
         complete_ff  <= 1'b0;
      end else if (advance) begin
         spinup_ms_ff <= spinup_ms_in;
         complete_ff  <= complete_in;
      end
   end

endmodule

FILE: hdl/qxm_mixer.sv
// X-frame mixer: four signed sums of the commands, saturated to the range
// from the idle PWM to PWM_FULL-1. Uses qxm_pkg.

module qxm_mixer #(
   parameter int PWM_FULL = qxm_pkg::PWM_FULL_DEF
) (
   input  qxm_pkg::cmd_type                     throttle,
   input  qxm_pkg::cmd_type                     yaw_cmd,
   input  qxm_pkg::cmd_type                     roll_cmd,
   input  qxm_pkg::cmd_type                     pitch_cmd,
   input  qxm_pkg::idle_pwm_type                idle,
   output qxm_pkg::pwm_type [qxm_pkg::MOTORS-1:0] motor
);

   localparam int SW = qxm_pkg::SUM_W;
   localparam logic signed [SW-1:0] PWM_MAX = SW'(PWM_FULL - 1);

   logic signed [SW-1:0] thr, yaw, roll, pitch, lo;
   logic signed [SW-1:0] sum [qxm_pkg::MOTORS];
   logic signed [SW-1:0] sat [qxm_pkg::MOTORS];

   assign thr   = SW'(throttle);
   assign yaw   = SW'(yaw_cmd);
   assign roll  = SW'(roll_cmd);
   assign pitch = SW'(pitch_cmd);
   assign lo    = signed'(SW'(idle));

   assign sum[0] = thr + yaw - roll + pitch;
   assign sum[1] = thr - yaw + roll + pitch;
   assign sum[2] = thr + yaw + roll - pitch;
   assign sum[3] = thr - yaw - roll - pitch;

   always_comb begin
      for (int k = 0; k < qxm_pkg::MOTORS; k++) begin
         if (sum[k] < lo) begin
            sat[k] = lo;
         end else if (sum[k] > PWM_MAX) begin
            sat[k] = PWM_MAX;
         end else begin
            sat[k] = sum[k];
         end
         motor[k] = sat[k][qxm_pkg::PWM_W-1:0];
      end
   end

endmodule

FILE: hdl/quad_x_motor_mixer_spinup.sv
// Top level of the quad X motor mixer with staggered spin-up.
// Depends on qxm_pkg, qxm_channels, qxm_spinup and qxm_mixer.
//
//   channel   direction  handshake            contents
//   req_bus   in         valid/ready          tick_ms, armed, four commands
//   rsp_bus   out        valid/ready          four motor PWM values, spinup_done
//   csr_      in         csr_wr_en, no wait   idle_speed setting
//
// One transaction enters per cycle while req_bus.ready is high; it passes the input
// register, then the result register, which loads when empty or the sink is ready.
// The spin-up state advances as each transaction moves into the result register.
// A stalled response holds; the input register still takes one more transaction.
// Synchronous active-high reset clears the spin-up state, valids and idle setting.

module quad_x_motor_mixer_spinup #(
   parameter int STAGE_TIME_MS = qxm_pkg::STAGE_TIME_MS_DEF,
   parameter int PWM_FULL      = qxm_pkg::PWM_FULL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [qxm_pkg::IDLE_W-1:0]  csr_wr_data,
   qxm_req_if.sink                     req_bus,
   qxm_rsp_if.source                   rsp_bus
);

   localparam int M = qxm_pkg::MOTORS;

   qxm_pkg::idle_pwm_type idle_pwm_ff;

   logic                             s1_valid_ff;
   logic [qxm_pkg::TICK_W-1:0]       s1_tick_ff;
   logic                             s1_armed_ff;
   qxm_pkg::cmd_type                 s1_thr_ff, s1_yaw_ff, s1_roll_ff, s1_pitch_ff;

   logic                             out_valid_ff;
   qxm_pkg::pwm_type [M-1:0]         out_motor_ff, out_motor_in;
   logic                             out_done_ff;

   logic                             req_take, out_load;
   qxm_pkg::spin_status_type         status;
   qxm_pkg::pwm_type [M-1:0]         mix_motor;

   assign out_load      = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || out_load;
   assign req_take      = req_bus.valid && req_bus.ready;

   qxm_spinup #(
      .STAGE_TIME_MS (STAGE_TIME_MS)
   ) u_spinup (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .armed   (s1_armed_ff),
      .tick_ms (s1_tick_ff),
      .status  (status)
   );

   qxm_mixer #(
      .PWM_FULL (PWM_FULL)
   ) u_mixer (
      .throttle  (s1_thr_ff),
      .yaw_cmd   (s1_yaw_ff),
      .roll_cmd  (s1_roll_ff),
      .pitch_cmd (s1_pitch_ff),
      .idle      (idle_pwm_ff),
      .motor     (mix_motor)
   );

   always_comb begin
      for (int k = 0; k < M; k++) begin
         if (status.mixing) begin
            out_motor_in[k] = mix_motor[k];
         end else if (status.motor_on[k]) begin
            out_motor_in[k] = qxm_pkg::PWM_W'(idle_pwm_ff);
         end else begin
            out_motor_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_pwm_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            idle_pwm_ff <= qxm_pkg::idle_pwm(csr_wr_data);
         end
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_tick_ff  <= req_bus.tick_ms;
         s1_armed_ff <= req_bus.armed;
         s1_thr_ff   <= req_bus.throttle;
         s1_yaw_ff   <= req_bus.yaw_cmd;
         s1_roll_ff  <= req_bus.roll_cmd;
         s1_pitch_ff <= req_bus.pitch_cmd;
      end
      if (out_load) begin
         out_motor_ff <= out_motor_in;
         out_done_ff  <= status.mixing;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.motor_front_right = out_motor_ff[0];
   assign rsp_bus.motor_front_left  = out_motor_ff[1];
   assign rsp_bus.motor_rear_left   = out_motor_ff[2];
   assign rsp_bus.motor_rear_right  = out_motor_ff[3];
   assign rsp_bus.spinup_done       = out_done_ff;

endmodule

FILE: hdl/qxm_checker.sv
// Port-level checker for the quad X motor mixer, bound to the top level.
// Depends on qxm_pkg and quad_x_motor_mixer_spinup.

module qxm_checker #(
   parameter int PWM_FULL = qxm_pkg::PWM_FULL_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input qxm_pkg::pwm_type motor_front_right,
   input qxm_pkg::pwm_type motor_front_left,
   input qxm_pkg::pwm_type motor_rear_left,
   input qxm_pkg::pwm_type motor_rear_right,
   input logic             spinup_done
);

   // A stalled response keeps its valid and its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({motor_front_right, motor_front_left,
                                                        motor_rear_left, motor_rear_right,
                                                        spinup_done}))
      else $error("response changed while stalled");

   // No response can be pending in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // During spin-up, running motors all show the same idle value and come on in order.
   a_spinup_stagger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !spinup_done |->
         (motor_front_left == '0 || motor_front_left == motor_front_right) &&
         (motor_rear_left == '0 || motor_rear_left == motor_front_right) &&
         (motor_rear_right == '0 || motor_rear_right == motor_front_right) &&
         (motor_rear_right == '0 || motor_rear_left != '0) &&
         (motor_rear_left == '0 || motor_front_left != '0))
      else $error("spin-up motors out of order");

   // Mixed outputs never exceed full scale when full scale fits the field.
   a_pwm_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && spinup_done |->
         (PWM_FULL > 1024) ||
         (int'(motor_front_right) < PWM_FULL && int'(motor_front_left) < PWM_FULL &&
          int'(motor_rear_left) < PWM_FULL && int'(motor_rear_right) < PWM_FULL))
      else $error("motor PWM above full scale");

endmodule

bind quad_x_motor_mixer_spinup qxm_checker #(
   .PWM_FULL (PWM_FULL)
) u_qxm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .motor_front_right (rsp_bus.motor_front_right),
   .motor_front_left  (rsp_bus.motor_front_left),
   .motor_rear_left   (rsp_bus.motor_rear_left),
   .motor_rear_right  (rsp_bus.motor_rear_right),
   .spinup_done       (rsp_bus.spinup_done)
);
